// ----- sv/dqr_pkg.sv -----
// Shared constants and helpers for the DNS query-to-A-reply rewriter.
package dqr_pkg;

    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int BYTE_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TTL     = 1'b1;

    localparam logic [CFG_W-1:0] ADDRESS_RESET = 32'hC0A8_0401;
    localparam logic [CFG_W-1:0] TTL_RESET     = 32'd120;

    localparam int MAX_DATAGRAM_DEF = 128;
    localparam int REPLY_OVERHEAD   = 17;

    // QR and AA bits as seen in the third header byte
    localparam logic [BYTE_W-1:0] FLAGS_QR_AA = 8'h84;
    localparam logic [BYTE_W-1:0] FLAG_QR     = 8'h80;
    localparam logic [BYTE_W-1:0] NAME_PTR_HI = 8'hC0;
    localparam logic [BYTE_W-1:0] NAME_PTR_LO = 8'h0C;

    localparam int IDX_W   = 5;
    localparam logic [IDX_W-1:0] HDR_LEN = 5'd6;
    localparam logic [IDX_W-1:0] ANS_LEN = 5'd17;

    localparam int HDR_BYTES = 6;

    // Answer record bytes after the last question byte (index 0)
    function automatic logic [BYTE_W-1:0] answer_byte(
        input logic [IDX_W-1:0] idx,
        input logic [CFG_W-1:0] ttl,
        input logic [CFG_W-1:0] addr
    );
        logic [BYTE_W-1:0] v;
        case (idx)
            5'd1:    v = NAME_PTR_HI;
            5'd2:    v = NAME_PTR_LO;
            5'd3:    v = 8'h00;
            5'd4:    v = 8'h01;
            5'd5:    v = 8'h00;
            5'd6:    v = 8'h01;
            5'd7:    v = ttl[31:24];
            5'd8:    v = ttl[23:16];
            5'd9:    v = ttl[15:8];
            5'd10:   v = ttl[7:0];
            5'd11:   v = 8'h00;
            5'd12:   v = 8'h04;
            5'd13:   v = addr[31:24];
            5'd14:   v = addr[23:16];
            5'd15:   v = addr[15:8];
            5'd16:   v = addr[7:0];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/dns_query_to_fixed_a_reply_top.sv -----
// DNS query-to-A-reply rewriter: parser, reply sequencer and output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | to block  | i_valid / o_stall  | i_data_byte, i_end_of_datagram
//  out     | from blk  | o_valid / i_stall  | o_reply_byte, o_last_of_reply, o_malformed
//  cfg     | to block  | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One datagram byte per cycle while o_stall is low; a reply byte passes from the job
// register to the output register. The sequencer emits one reply byte per cycle while
// i_stall is low, so the sixth header byte and the byte closing the question hold the
// input during their bursts. i_stall holds the output register and the sequencer; the
// input stalls while a job's last byte is not yet popped. Synchronous active-low reset.
module dns_query_to_fixed_a_reply_top #(
    parameter int MAX_DATAGRAM = dqr_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_datagram,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_reply_byte,
    output logic                          o_last_of_reply,
    output logic                          o_malformed,
    input  logic                          i_cfg_we,
    input  logic [dqr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dqr_pkg::CFG_W-1:0]     i_cfg_data
);
    import dqr_pkg::*;

    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_DATAGRAM);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATAGRAM - REPLY_OVERHEAD);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_FIXED   = 3'd1;
    localparam logic [2:0] PH_LABLEN  = 3'd2;
    localparam logic [2:0] PH_LABEL   = 3'd3;
    localparam logic [2:0] PH_TAIL    = 3'd4;
    localparam logic [2:0] PH_SWALLOW = 3'd5;

    localparam logic [1:0] JOB_SINGLE = 2'd0;
    localparam logic [1:0] JOB_HEADER = 2'd1;
    localparam logic [1:0] JOB_ANSWER = 2'd2;

    logic [CFG_W-1:0]  r_address;
    logic [CFG_W-1:0]  r_ttl;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [2:0]        r_phase, n_phase;
    logic [7:0]        r_lbl, n_lbl;
    logic [2:0]        r_tail, n_tail;
    logic [7:0]        r_hdr [HDR_BYTES];

    logic              r_job_valid;
    logic [1:0]        r_job_kind, n_job_kind;
    logic [IDX_W-1:0]  r_job_idx;
    logic [7:0]        r_job_byte, n_job_byte;
    logic              r_job_last, n_job_last;
    logic              r_job_bad, n_job_bad;
    logic              n_job_valid;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_bad;

    logic              in_acc;
    logic              out_free;
    logic              pop_last;
    logic [IDX_W-1:0]  job_cnt;
    logic [7:0]        pop_byte;
    logic              pop_last_flag;
    logic              pop_bad;
    logic              hdr_we;
    logic              replying;
    logic              done;
    logic              bad;
    logic [7:0]        lbl_dec;
    logic [2:0]        tail_dec;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= ADDRESS_RESET;
            r_ttl     <= TTL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ANSWER_ADDRESS: r_address <= i_cfg_data;
                CFG_ANSWER_TTL:     r_ttl     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer pop
    always_comb begin
        case (r_job_kind)
            JOB_HEADER: job_cnt = HDR_LEN;
            JOB_ANSWER: job_cnt = ANS_LEN;
            default:    job_cnt = 5'd1;
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;
    assign pop_last = r_job_valid && out_free && (r_job_idx == job_cnt - 5'd1);
    assign o_stall  = r_job_valid && !pop_last;
    assign in_acc   = i_valid && !o_stall;

    always_comb begin
        pop_byte      = r_job_byte;
        pop_last_flag = 1'b0;
        pop_bad       = 1'b0;
        case (r_job_kind)
            JOB_HEADER: begin
                case (r_job_idx)
                    5'd0:    pop_byte = r_hdr[0];
                    5'd1:    pop_byte = r_hdr[1];
                    5'd2:    pop_byte = r_hdr[2] | FLAGS_QR_AA;
                    5'd3:    pop_byte = r_hdr[3];
                    5'd4:    pop_byte = r_hdr[4];
                    default: pop_byte = r_hdr[5];
                endcase
            end
            JOB_ANSWER: begin
                if (r_job_idx != 5'd0) begin
                    pop_byte = answer_byte(r_job_idx, r_ttl, r_address);
                end
                pop_last_flag = (r_job_idx == ANS_LEN - 5'd1);
            end
            default: begin
                pop_last_flag = r_job_last;
                pop_bad       = r_job_bad;
            end
        endcase
    end

    // parser
    assign lbl_dec  = (r_lbl != 8'd0) ? r_lbl - 8'd1 : 8'd0;
    assign tail_dec = (r_tail != 3'd0) ? r_tail - 3'd1 : 3'd0;

    always_comb begin
        n_phase     = r_phase;
        n_lbl       = r_lbl;
        n_tail      = r_tail;
        n_job_valid = 1'b0;
        n_job_kind  = JOB_SINGLE;
        n_job_byte  = i_data_byte;
        n_job_last  = 1'b0;
        n_job_bad   = 1'b0;
        hdr_we      = 1'b0;
        replying    = 1'b0;
        done        = 1'b0;
        bad         = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                hdr_we = (r_pos < POS_W'(HDR_BYTES));
                if (r_pos >= POS_W'(5)) begin
                    if (((r_hdr[2] & FLAG_QR) != 8'd0) || ((r_hdr[4] | i_data_byte) == 8'd0)) begin
                        n_phase = PH_SWALLOW;
                    end else begin
                        replying = 1'b1;
                        if (r_pos > POS_LIMIT) begin
                            bad = 1'b1;
                        end else begin
                            n_job_valid = 1'b1;
                            n_job_kind  = JOB_HEADER;
                            n_phase     = PH_FIXED;
                        end
                    end
                end else begin
                    replying = 1'b1;
                end
            end
            PH_FIXED, PH_LABLEN, PH_LABEL, PH_TAIL: begin
                replying = 1'b1;
                if (r_pos > POS_LIMIT) begin
                    bad = 1'b1;
                end else begin
                    n_job_valid = 1'b1;
                    case (r_phase)
                        PH_FIXED: begin
                            if (r_pos == POS_W'(6)) begin
                                n_job_byte = r_hdr[4];
                            end else if (r_pos == POS_W'(7)) begin
                                n_job_byte = r_hdr[5];
                            end
                            if (r_pos >= POS_W'(11)) begin
                                n_phase = PH_LABLEN;
                            end
                        end
                        PH_LABLEN: begin
                            if (i_data_byte == 8'd0) begin
                                n_phase = PH_TAIL;
                                n_tail  = 3'd4;
                            end else begin
                                n_lbl   = i_data_byte;
                                n_phase = PH_LABEL;
                            end
                        end
                        PH_LABEL: begin
                            n_lbl = lbl_dec;
                            if (lbl_dec == 8'd0) begin
                                n_phase = PH_LABLEN;
                            end
                        end
                        default: begin
                            n_tail = tail_dec;
                            if (tail_dec == 3'd0) begin
                                n_job_kind = JOB_ANSWER;
                                done       = 1'b1;
                                n_phase    = PH_SWALLOW;
                            end
                        end
                    endcase
                end
            end
            default: n_phase = PH_SWALLOW;
        endcase

        if (replying && (bad || (i_end_of_datagram && !done))) begin
            n_job_valid = 1'b1;
            n_job_kind  = JOB_SINGLE;
            n_job_byte  = 8'd0;
            n_job_last  = 1'b1;
            n_job_bad   = 1'b1;
            n_phase     = PH_SWALLOW;
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;

        if (i_end_of_datagram) begin
            n_pos   = '0;
            n_phase = PH_HEADER;
            n_lbl   = 8'd0;
            n_tail  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEADER;
            r_lbl   <= 8'd0;
            r_tail  <= 3'd0;
        end else if (in_acc) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_lbl   <= n_lbl;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && hdr_we) begin
            r_hdr[r_pos[2:0]] <= i_data_byte;
        end
    end

    // job register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (in_acc) begin
            r_job_valid <= n_job_valid;
        end else if (pop_last) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_job_kind <= n_job_kind;
            r_job_idx  <= '0;
            r_job_byte <= n_job_byte;
            r_job_last <= n_job_last;
            r_job_bad  <= n_job_bad;
        end else if (r_job_valid && out_free) begin
            r_job_idx <= r_job_idx + 5'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_byte <= pop_byte;
            r_out_last <= pop_last_flag;
            r_out_bad  <= pop_bad;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_reply_byte    = r_out_byte;
    assign o_last_of_reply = r_out_last;
    assign o_malformed     = r_out_bad;

    a_malformed_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_malformed) |-> (o_last_of_reply && (o_reply_byte == 8'd0)))
        else $error("malformed item is not a zero final byte");

    a_job_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_idx < job_cnt))
        else $error("sequencer index past burst length");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position past limit");

    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_job_valid && (r_job_kind != JOB_SINGLE || !out_free)))
        else $error("input stalled without a pending burst");

endmodule

// ----- test/tb.sv -----
// Testbench for dns_query_to_fixed_a_reply_top: streams datagrams and checks every reply item.
`timescale 1ns / 100ps

module tb;
    import dqr_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } t_dgram_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_reply;

    typedef enum logic [2:0] {
        ST_HOLD, ST_FIXED, ST_LEN, ST_LABEL, ST_TAIL, ST_SKIP
    } t_parse_st;

    localparam logic [15:0] RR_TYPE_A   = 16'h0001;
    localparam logic [15:0] RR_CLASS_IN = 16'h0001;
    localparam logic [15:0] RR_RDLENGTH = 16'h0004;
    localparam int QTAIL_BYTES  = 4;
    localparam int FIXED_END    = 11;
    localparam int LAST_SAFE    = MAX_DATAGRAM_DEF - REPLY_OVERHEAD;
    localparam int SETTLE_CYC   = 40;
    localparam int PHASE_BYTES  = 30;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_end_of_datagram = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [7:0]           o_reply_byte;
    logic                 o_last_of_reply;
    logic                 o_malformed;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ANSWER_ADDRESS;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    dns_query_to_fixed_a_reply_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_reply_byte      (o_reply_byte),
        .o_last_of_reply   (o_last_of_reply),
        .o_malformed       (o_malformed),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_dgram_item pending_q[$];
    t_reply      reply_q[$];
    logic [7:0]  dgram[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int queued_cnt    = 0;
    int taken_cnt     = 0;
    int phase_bytes   = 0;
    int mismatch_cnt  = 0;
    logic in_taken    = 1'b0;

    // predictor state
    logic [CFG_W-1:0] cfg_address = ADDRESS_RESET;
    logic [CFG_W-1:0] cfg_ttl     = TTL_RESET;
    logic [7:0]       hdr [HDR_BYTES];
    t_parse_st        dg_phase    = ST_HOLD;
    int               dg_pos      = 0;
    logic [7:0]       label_left  = '0;
    logic [2:0]       tail_left   = '0;

    t_reply got;
    t_reply want;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic predict_reply(input logic [7:0] b, input logic eod);
        t_reply burst[$];
        logic   replying;
        logic   done;
        logic   bad;
        int     s;
        replying = 1'b0;
        done     = 1'b0;
        bad      = 1'b0;
        case (dg_phase)
            ST_HOLD: begin
                if (dg_pos < HDR_BYTES) hdr[dg_pos] = b;
                if (dg_pos >= HDR_BYTES - 1) begin
                    if ((hdr[2] & FLAG_QR) != 0 || {hdr[4], hdr[5]} == 16'h0000) begin
                        dg_phase = ST_SKIP;
                    end else begin
                        replying = 1'b1;
                        if (dg_pos > LAST_SAFE) begin
                            bad = 1'b1;
                        end else begin
                            burst.push_back({hdr[0], 2'b00});
                            burst.push_back({hdr[1], 2'b00});
                            burst.push_back({hdr[2] | FLAGS_QR_AA, 2'b00});
                            burst.push_back({hdr[3], 2'b00});
                            burst.push_back({hdr[4], 2'b00});
                            burst.push_back({hdr[5], 2'b00});
                            dg_phase = ST_FIXED;
                        end
                    end
                end else begin
                    replying = 1'b1;
                end
            end
            ST_FIXED, ST_LEN, ST_LABEL, ST_TAIL: begin
                replying = 1'b1;
                if (dg_pos > LAST_SAFE) begin
                    bad = 1'b1;
                end else if (dg_phase == ST_FIXED) begin
                    // answer count takes the question count
                    if (dg_pos == 6) burst.push_back({hdr[4], 2'b00});
                    else if (dg_pos == 7) burst.push_back({hdr[5], 2'b00});
                    else burst.push_back({b, 2'b00});
                    if (dg_pos >= FIXED_END) dg_phase = ST_LEN;
                end else if (dg_phase == ST_LEN) begin
                    burst.push_back({b, 2'b00});
                    if (b == 8'h00) begin
                        dg_phase  = ST_TAIL;
                        tail_left = 3'(QTAIL_BYTES);
                    end else begin
                        label_left = b;
                        dg_phase   = ST_LABEL;
                    end
                end else if (dg_phase == ST_LABEL) begin
                    burst.push_back({b, 2'b00});
                    if (label_left > 0) label_left--;
                    if (label_left == 0) dg_phase = ST_LEN;
                end else begin
                    burst.push_back({b, 2'b00});
                    if (tail_left > 0) tail_left--;
                    if (tail_left == 0) begin
                        burst.push_back({NAME_PTR_HI, 2'b00});
                        burst.push_back({NAME_PTR_LO, 2'b00});
                        burst.push_back({RR_TYPE_A[15:8], 2'b00});
                        burst.push_back({RR_TYPE_A[7:0], 2'b00});
                        burst.push_back({RR_CLASS_IN[15:8], 2'b00});
                        burst.push_back({RR_CLASS_IN[7:0], 2'b00});
                        for (s = 24; s >= 0; s -= 8)
                            burst.push_back({cfg_ttl[s +: 8], 2'b00});
                        burst.push_back({RR_RDLENGTH[15:8], 2'b00});
                        burst.push_back({RR_RDLENGTH[7:0], 2'b00});
                        for (s = 24; s >= 0; s -= 8)
                            burst.push_back({cfg_address[s +: 8], s == 0, 1'b0});
                        done     = 1'b1;
                        dg_phase = ST_SKIP;
                    end
                end
            end
            default: dg_phase = ST_SKIP;
        endcase

        if (replying && (bad || (eod && !done))) begin
            burst.delete();
            burst.push_back({8'h00, 1'b1, 1'b1});
            dg_phase = ST_SKIP;
        end
        if (dg_pos < MAX_DATAGRAM_DEF) dg_pos++;
        if (eod) begin
            dg_pos     = 0;
            dg_phase   = ST_HOLD;
            label_left = '0;
            tail_left  = '0;
        end
        foreach (burst[k]) reply_q.push_back(burst[k]);
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_dgram_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                i_valid           <= 1'b1;
                i_data_byte       <= nxt.data;
                i_end_of_datagram <= nxt.eod;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // monitor and checker
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                taken_cnt++;
                predict_reply(i_data_byte, i_end_of_datagram);
            end
            if (o_valid && !i_stall) begin
                got = {o_reply_byte, o_last_of_reply, o_malformed};
                if (reply_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply item %h", got));
                end else begin
                    want = reply_q.pop_front();
                    if (got.data !== want.data)
                        report_mismatch($sformatf("reply_byte %h, want %h",
                                                  got.data, want.data));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_of_reply %b, want %b",
                                                  got.last, want.last));
                    if (got.bad !== want.bad)
                        report_mismatch($sformatf("malformed %b, want %b",
                                                  got.bad, want.bad));
                end
            end
        end
    end

    task automatic send_dgram();
        foreach (dgram[k]) begin
            pending_q.push_back({dgram[k], k == dgram.size() - 1});
            queued_cnt++;
        end
        phase_bytes += dgram.size();
    endtask

    task automatic make_query(input int name_len, input int extra);
        int rem;
        int len;
        int qd;
        dgram.delete();
        dgram.push_back(8'($urandom_range(0, 255)));
        dgram.push_back(8'($urandom_range(0, 255)));
        dgram.push_back(8'($urandom_range(0, 255)) & ~FLAG_QR);
        dgram.push_back(8'($urandom_range(0, 255)));
        qd = ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(1, 65535);
        dgram.push_back(qd[15:8]);
        dgram.push_back(qd[7:0]);
        repeat (6) dgram.push_back(8'($urandom_range(0, 255)));
        rem = name_len - 1;
        while (rem > 0) begin
            if (rem <= 64) begin
                len = rem - 1;
            end else begin
                len = $urandom_range(1, 62);
                if (rem - len - 1 == 1) len++;
            end
            dgram.push_back(8'(len));
            repeat (len) dgram.push_back(8'($urandom_range(0, 255)));
            rem -= len + 1;
        end
        dgram.push_back(8'h00);
        repeat (QTAIL_BYTES + extra) dgram.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic int short_name();
        int l;
        l = $urandom_range(1, 24);
        return (l == 2) ? 3 : l;
    endfunction

    task automatic truncate(input int n);
        while (dgram.size() > n) void'(dgram.pop_back());
    endtask

    task automatic drain();
        while (taken_cnt != queued_cnt || reply_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ANSWER_ADDRESS) cfg_address = val;
        else cfg_ttl = val;
    endtask

    task automatic random_dgram();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            make_query(short_name(), $urandom_range(0, 3));
        end else if (kind < 65) begin
            make_query(short_name(), 0);
            truncate($urandom_range(1, dgram.size() - 1));
        end else if (kind < 72) begin
            make_query(short_name(), $urandom_range(0, 3));
            dgram[2] = dgram[2] | FLAG_QR;
            truncate($urandom_range(1, dgram.size()));
        end else if (kind < 79) begin
            make_query(short_name(), $urandom_range(0, 3));
            dgram[4] = 8'h00;
            dgram[5] = 8'h00;
            truncate($urandom_range(5, dgram.size()));
        end else if (kind < 84) begin
            // oversized label length, including compression-pointer values
            make_query($urandom_range(3, 24), $urandom_range(0, 3));
            dgram[12] = 8'($urandom_range(8'h40, 8'hFF));
        end else if (kind < 90) begin
            dgram.delete();
            repeat ($urandom_range(1, 20)) dgram.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 95) begin
            // reply ends right around the size limit
            make_query($urandom_range(94, 98), $urandom_range(0, 20));
        end else begin
            make_query($urandom_range(100, 120), $urandom_range(0, 4));
        end
        send_dgram();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme header and name bytes, drop on sixth byte, early end
        dgram = '{8'hFF, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00,
                  8'h01, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_dgram();
        dgram = '{8'h00, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01};
        send_dgram();
        dgram = '{8'h12, 8'h34};
        send_dgram();
        drain();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_ANSWER_ADDRESS, '0);
                    write_reg(CFG_ANSWER_TTL, '0);
                    send_idle_pct = 74; stall_pct = 0;
                end
                2: begin
                    write_reg(CFG_ANSWER_ADDRESS, '1);
                    write_reg(CFG_ANSWER_TTL, '1);
                    send_idle_pct = 0; stall_pct = 74;
                end
                3: begin
                    write_reg(CFG_ANSWER_ADDRESS, $urandom());
                    write_reg(CFG_ANSWER_TTL, $urandom());
                    send_idle_pct = 17; stall_pct = 17;
                end
                4: begin
                    write_reg(CFG_ANSWER_TTL, $urandom());
                    send_idle_pct = 0; stall_pct = 0;
                end
                default: begin
                    write_reg(CFG_ANSWER_ADDRESS, $urandom());
                    send_idle_pct = 74; stall_pct = 74;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) random_dgram();
            drain();
        end

        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d reply items never arrived", reply_q.size()));
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
